// ===== src/gelu_tanh_forward_backward_unit_top_macros.svh =====
// Assertion macros shared by the GELU unit RTL.
`ifndef GELU_TANH_FORWARD_BACKWARD_UNIT_TOP_MACROS_SVH
`define GELU_TANH_FORWARD_BACKWARD_UNIT_TOP_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define GELU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define GELU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/gelu_pkg.sv =====
// Package with constants and the pipeline item type of the GELU unit.
`timescale 1ns / 1ps

package gelu_pkg;

  localparam int DW           = 16;
  localparam int FRONT_STAGES = 15;
  localparam int DIV_STAGES   = 17;
  localparam int BACK_STAGES  = 6;
  localparam int HORNER_STEPS = 5;

  localparam logic       CMD_FWD = 1'b0;
  localparam logic       CMD_BWD = 1'b1;

  localparam logic [16:0] K_Q16      = 17'd52290;
  localparam logic [11:0] C_Q16      = 12'd2930;
  localparam logic [13:0] C3_Q16     = 14'd8791;
  localparam logic [17:0] LOG2E2_Q16 = 18'd189096;
  localparam logic [16:0] ONE_Q16    = 17'd65536;
  localparam logic [16:0] POW2_C0    = 17'd10;

  localparam logic [15:0] POW2_COEF [HORNER_STEPS] =
    '{16'd87, 16'd630, 16'd3638, 16'd15743, 16'd45426};

  localparam logic [DW-1:0] RES_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] RES_MIN = {1'b1, {(DW-1){1'b0}}};

  typedef struct packed {
    logic                 vld;
    logic                 cmd;
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] grad;
    logic [18:0]          x2;
    logic signed [35:0]   m1;
    logic [32:0]          app;
    logic signed [47:0]   m2;
    logic [20:0]          apin;
    logic signed [19:0]   u;
    logic [36:0]          apx;
    logic signed [35:0]   ka;
    logic [20:0]          ap;
    logic                 neg;
    logic [19:0]          aa;
    logic [37:0]          yp;
    logic [9:0]           n;
    logic [16:0]          gf;
    logic [16:0]          p;
    logic [17:0]          ee;
    logic [17:0]          rem;
    logic                 num;
    logic [17:0]          den;
    logic [16:0]          q;
    logic signed [17:0]   ts;
    logic signed [35:0]   f;
    logic [33:0]          tt;
    logic [37:0]          dtp;
    logic signed [37:0]   xd;
    logic signed [27:0]   d;
    logic signed [43:0]   gd;
    logic [DW-1:0]        res;
    logic                 sat;
  } item_t;

endpackage

// ===== src/gelu_tanh_forward_backward_unit_top.sv =====
// GELU unit (tanh approximation), forward and backward, signed Q4.12.
`timescale 1ns / 1ps
`include "gelu_tanh_forward_backward_unit_top_macros.svh"

// One transaction in gives one transaction out, passing through 15 stages
// for the polynomial argument, log2e scaling and the 2^-y Horner evaluation,
// 17 divider stages (one quotient bit each) forming tanh, and 6 stages for the
// derivative, the final product and saturation. A new transaction is taken
// every cycle; the whole pipeline holds together while a finished result sits
// unaccepted in the output stage. in_tdata = {grad_in, x_value}; in_tuser = cmd
// (0 forward, 1 backward); out_tdata = result_value; out_tuser = saturated.
module gelu_tanh_forward_backward_unit_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] x_value, [31:16] grad_in
  input  logic [0:0]  in_tuser,   // [0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] result_value
  output logic [0:0]  out_tuser   // [0] saturated
);

  localparam int FL = gelu_pkg::FRONT_STAGES - 1;
  localparam int BL = gelu_pkg::BACK_STAGES - 1;

  gelu_pkg::item_t f_r   [gelu_pkg::FRONT_STAGES];
  gelu_pkg::item_t f_nxt [gelu_pkg::FRONT_STAGES];
  gelu_pkg::item_t b_r   [gelu_pkg::BACK_STAGES];
  gelu_pkg::item_t b_nxt [gelu_pkg::BACK_STAGES];
  gelu_pkg::item_t dq;
  logic            en;

  assign en        = !b_r[BL].vld || out_tready;
  assign in_tready = en;

  // square of x
  always_comb begin
    logic signed [31:0] sq;
    f_nxt[0]      = '0;
    f_nxt[0].vld  = in_tvalid;
    f_nxt[0].cmd  = in_tuser[0];
    f_nxt[0].x    = in_tdata[15:0];
    f_nxt[0].grad = in_tdata[31:16];
    sq            = f_nxt[0].x * f_nxt[0].x;
    f_nxt[0].x2   = sq[30:12];
  end

  always_comb begin
    f_nxt[1]     = f_r[0];
    f_nxt[1].m1  = f_r[0].x * $signed({1'b0, f_r[0].x2});
    f_nxt[1].app = gelu_pkg::C3_Q16 * f_r[0].x2;
  end

  always_comb begin
    logic [32:0] t2;
    f_nxt[2]      = f_r[1];
    f_nxt[2].m2   = $signed({1'b0, gelu_pkg::C_Q16}) * f_r[1].m1;
    t2            = f_r[1].app + 33'd2048;
    f_nxt[2].apin = {4'd0, gelu_pkg::ONE_Q16} + t2[32:12];
  end

  always_comb begin
    logic signed [47:0] t3;
    logic signed [47:0] cr;
    f_nxt[3]     = f_r[2];
    t3           = f_r[2].m2 + 48'sd134217728;
    cr           = t3 >>> 28;
    f_nxt[3].u   = 20'(f_r[2].x) + $signed(cr[19:0]);
    f_nxt[3].apx = gelu_pkg::K_Q16 * f_r[2].apin;
  end

  always_comb begin
    logic [36:0] t4;
    f_nxt[4]    = f_r[3];
    f_nxt[4].ka = $signed({1'b0, gelu_pkg::K_Q16}) * f_r[3].u;
    t4          = f_r[3].apx + 37'd32768;
    f_nxt[4].ap = t4[36:16];
  end

  always_comb begin
    logic signed [35:0] t5;
    logic signed [35:0] a5;
    logic [19:0]        av;
    f_nxt[5]     = f_r[4];
    t5           = f_r[4].ka + 36'sd32768;
    a5           = t5 >>> 16;
    av           = a5[19:0];
    f_nxt[5].neg = av[19];
    f_nxt[5].aa  = av[19] ? (~av + 20'd1) : av;
  end

  always_comb begin
    f_nxt[6]    = f_r[5];
    f_nxt[6].yp = f_r[5].aa * gelu_pkg::LOG2E2_Q16;
  end

  always_comb begin
    logic [37:0] t7;
    f_nxt[7]    = f_r[6];
    t7          = f_r[6].yp + 38'd2048;
    f_nxt[7].n  = t7[37:28];
    f_nxt[7].gf = gelu_pkg::ONE_Q16 - {1'b0, t7[27:12]};
  end

  for (genvar k = 0; k < gelu_pkg::HORNER_STEPS; k++) begin : g_horner
    always_comb begin
      logic [16:0] pin;
      logic [33:0] prod;
      pin            = (k == 0) ? gelu_pkg::POW2_C0 : f_r[7+k].p;
      prod           = pin * f_r[7+k].gf;
      f_nxt[8+k]     = f_r[7+k];
      f_nxt[8+k].p   = {1'b0, gelu_pkg::POW2_COEF[k]} + prod[32:16];
    end
  end

  always_comb begin
    logic [33:0] prod;
    f_nxt[13]    = f_r[12];
    prod         = f_r[12].p * f_r[12].gf;
    f_nxt[13].ee = {1'b0, gelu_pkg::ONE_Q16} + {1'b0, prod[32:16]};
  end

  // e = E >> (n+1), then seed the divider with (1-e)/(1+e)
  always_comb begin
    logic [4:0]  sh;
    logic [17:0] e18;
    logic [16:0] e17;
    logic [16:0] om;
    f_nxt[14] = f_r[13];
    sh        = f_r[13].n[4:0] + 5'd1;
    e18       = f_r[13].ee >> sh;
    e17       = (f_r[13].n >= 10'd17) ? 17'd0 : e18[16:0];
    om        = gelu_pkg::ONE_Q16 - e17;
    f_nxt[14].rem = {2'b00, om[16:1]};
    f_nxt[14].num = om[0];
    f_nxt[14].den = {1'b0, gelu_pkg::ONE_Q16} + {1'b0, e17};
    f_nxt[14].q   = '0;
  end

  for (genvar i = 0; i < gelu_pkg::FRONT_STAGES; i++) begin : g_front
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        f_r[i].vld <= 1'b0;
      end else if (en) begin
        f_r[i] <= f_nxt[i];
      end
    end
  end

  gelu_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .en   (en),
    .din  (f_r[FL]),
    .dout (dq)
  );

  always_comb begin
    logic signed [17:0] qs;
    logic signed [18:0] opnd;
    b_nxt[0]    = dq;
    qs          = $signed({1'b0, dq.q});
    b_nxt[0].ts = dq.neg ? -qs : qs;
    opnd        = 19'sd65536 + 19'(b_nxt[0].ts);
    b_nxt[0].f  = dq.x * opnd;
    b_nxt[0].tt = dq.q * dq.q;
  end

  always_comb begin
    logic [16:0] s;
    b_nxt[1]     = b_r[0];
    s            = gelu_pkg::ONE_Q16 - b_r[0].tt[32:16];
    b_nxt[1].dtp = s * b_r[0].ap;
  end

  always_comb begin
    logic [37:0] t;
    b_nxt[2]    = b_r[1];
    t           = b_r[1].dtp + 38'd32768;
    b_nxt[2].xd = b_r[1].x * $signed({1'b0, t[37:16]});
  end

  always_comb begin
    logic signed [37:0] tx;
    logic signed [37:0] xr;
    b_nxt[3]   = b_r[2];
    tx         = b_r[2].xd + 38'sd2048;
    xr         = tx >>> 12;
    b_nxt[3].d = 28'sd65536 + 28'(b_r[2].ts) + $signed(xr[27:0]);
  end

  always_comb begin
    b_nxt[4]    = b_r[3];
    b_nxt[4].gd = b_r[3].grad * b_r[3].d;
  end

  // round, select by command, clamp
  always_comb begin
    logic signed [43:0] tg;
    logic signed [35:0] tf;
    logic signed [35:0] rf;
    logic signed [43:0] rr;
    b_nxt[5] = b_r[4];
    tg       = b_r[4].gd + 44'sd65536;
    tf       = b_r[4].f + 36'sd65536;
    rf       = tf >>> 17;
    rr       = (b_r[4].cmd == gelu_pkg::CMD_BWD) ? (tg >>> 17) : 44'(rf);
    if (rr > 44'sd32767) begin
      b_nxt[5].res = gelu_pkg::RES_MAX;
      b_nxt[5].sat = 1'b1;
    end else if (rr < -44'sd32768) begin
      b_nxt[5].res = gelu_pkg::RES_MIN;
      b_nxt[5].sat = 1'b1;
    end else begin
      b_nxt[5].res = rr[15:0];
      b_nxt[5].sat = 1'b0;
    end
  end

  for (genvar i = 0; i < gelu_pkg::BACK_STAGES; i++) begin : g_back
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        b_r[i].vld <= 1'b0;
      end else if (en) begin
        b_r[i] <= b_nxt[i];
      end
    end
  end

  assign out_tvalid   = b_r[BL].vld;
  assign out_tdata    = b_r[BL].res;
  assign out_tuser[0] = b_r[BL].sat;

  `GELU_ASSERT_IMP(a_sat_on_rail, out_tvalid && out_tuser[0], out_tdata == gelu_pkg::RES_MAX || out_tdata == gelu_pkg::RES_MIN, "saturated result not on a rail")
  `GELU_ASSERT_IMP(a_fwd_in_range, out_tvalid && b_r[BL].cmd == gelu_pkg::CMD_FWD, !out_tuser[0], "forward result saturated")
  `GELU_ASSERT_IMP(a_tanh_bound, dq.vld, dq.q <= gelu_pkg::ONE_Q16, "tanh magnitude above one")

endmodule

// ===== src/gelu_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, giving the tanh magnitude in Q16.
`timescale 1ns / 1ps

module gelu_div (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  gelu_pkg::item_t din,
  output gelu_pkg::item_t dout
);

  gelu_pkg::item_t st_r   [gelu_pkg::DIV_STAGES];
  gelu_pkg::item_t st_nxt [gelu_pkg::DIV_STAGES];

  for (genvar j = 0; j < gelu_pkg::DIV_STAGES; j++) begin : g_step
    always_comb begin
      gelu_pkg::item_t src;
      logic [17:0]     r2;
      src = (j == 0) ? din : st_r[(j == 0) ? 0 : j - 1];
      r2  = {src.rem[16:0], src.num};
      st_nxt[j]     = src;
      st_nxt[j].num = 1'b0;
      if (r2 >= src.den) begin
        st_nxt[j].rem = r2 - src.den;
        st_nxt[j].q   = {src.q[15:0], 1'b1};
      end else begin
        st_nxt[j].rem = r2;
        st_nxt[j].q   = {src.q[15:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[j].vld <= 1'b0;
      end else if (en) begin
        st_r[j] <= st_nxt[j];
      end
    end
  end

  assign dout = st_r[gelu_pkg::DIV_STAGES-1];

endmodule
